### hw/rtl/emsr_pkg.sv
// ----------------------------------------------------------------------------
// emsr_pkg
// Shared types and constants for the extent map sector remapper.
// ----------------------------------------------------------------------------
`default_nettype none

package emsr_pkg;

   localparam int MAX_EXTENTS_DEF = 256;
   localparam int SECTOR_W        = 31;
   localparam int COUNT_OUT_W     = 9;

   typedef enum logic {
      CMD_LOOKUP = 1'b0,
      CMD_MAP    = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPEND,
      ST_SHIFT
   } state_type;

   typedef enum logic {
      PH_FIND,
      PH_PREV
   } phase_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [SECTOR_W-1:0] logical_sector;
      logic [SECTOR_W-1:0] physical_sector;
   } req_type;

   typedef struct packed {
      logic                   found;
      logic [SECTOR_W-1:0]    mapped_sector;
      logic                   status;
      logic                   writable;
      logic [COUNT_OUT_W-1:0] extent_count;
   } rsp_type;

   typedef struct packed {
      logic [SECTOR_W-1:0] ls;
      logic [SECTOR_W-1:0] ps;
      logic [SECTOR_W-1:0] len;
   } entry_type;

endpackage

`default_nettype wire

### hw/rtl/emsr_ram.sv
// ----------------------------------------------------------------------------
// emsr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module emsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### hw/rtl/extent_map_sector_remapper_top.sv
// ----------------------------------------------------------------------------
// extent_map_sector_remapper_top
// Extent table with lookup and single-sector remap requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its one result shows
// on rsp_data for a single cycle with rsp_valid, and cannot be held off. The
// extent table sits in one RAM and is walked one entry per cycle through its
// registered read port. A lookup holds busy until its walk ends, and no new
// request is taken while busy is high.
// A map request walks the table once to find the sector, again after each
// trim or split, once more to find the preceding extent, and a delete shifts
// the entries above it down one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module extent_map_sector_remapper_top #(
   parameter int MAX_EXTENTS = emsr_pkg::MAX_EXTENTS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire emsr_pkg::req_type req_data,
   output logic                  rsp_valid,
   output emsr_pkg::rsp_type     rsp_data
);

   localparam int IDX_W = $clog2(MAX_EXTENTS);
   localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
   localparam int SW    = emsr_pkg::SECTOR_W;

   emsr_pkg::state_type state_ff, state_in;
   emsr_pkg::phase_type phase_ff, phase_in;
   emsr_pkg::cmd_type   cmd_ff, cmd_in;
   logic [SW-1:0]       sec_ff, sec_in, phys_ff, phys_in;
   logic                single_ff, single_in;
   logic [IDX_W-1:0]    k_ff, k_in;
   emsr_pkg::entry_type ent_ff, ent_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                rv_ff, rv_in;
   logic [IDX_W-1:0]    ridx_ff, ridx_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                wr_ff, wr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   emsr_pkg::rsp_type   rsp_ff, rsp_in;

   logic                we;
   logic [IDX_W-1:0]    waddr, raddr;
   emsr_pkg::entry_type wdata, rd;

   emsr_ram #(
      .WIDTH ($bits(emsr_pkg::entry_type)),
      .DEPTH (MAX_EXTENTS)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rd)
   );

   logic [SW-1:0] tgt;
   logic          hit, cont, full, resp_now, resp_found, resp_status;
   logic [SW-1:0] resp_mapped, lo;

   always_comb begin
      tgt  = (phase_ff == emsr_pkg::PH_PREV) ? sec_ff - 1'b1 : sec_ff;
      hit  = rv_ff && (rd.ls <= tgt) && (({1'b0, rd.ls} + {1'b0, rd.len}) > {1'b0, tgt});
      cont = (({1'b0, rd.ls} + {1'b0, rd.len}) == {1'b0, sec_ff}) &&
             (({1'b0, rd.ps} + {1'b0, rd.len}) == {1'b0, phys_ff});
      full = (count_ff == CNT_W'(MAX_EXTENTS));
      lo   = sec_ff - ent_ff.ls;
   end

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      cmd_in      = cmd_ff;
      sec_in      = sec_ff;
      phys_in     = phys_ff;
      single_in   = single_ff;
      k_in        = k_ff;
      ent_in      = ent_ff;
      idx_in      = idx_ff;
      rv_in       = 1'b0;
      ridx_in     = ridx_ff;
      count_in    = count_ff;
      wr_in       = wr_ff;
      we          = 1'b0;
      waddr       = '0;
      wdata       = rd;
      raddr       = idx_ff[IDX_W-1:0];
      resp_now    = 1'b0;
      resp_found  = 1'b0;
      resp_mapped = '0;
      resp_status = 1'b0;

      unique case (state_ff)
         emsr_pkg::ST_IDLE: begin
            if (start) begin
               cmd_in   = req_data.cmd;
               sec_in   = req_data.logical_sector;
               phys_in  = req_data.physical_sector;
               phase_in = emsr_pkg::PH_FIND;
               idx_in   = '0;
               state_in = emsr_pkg::ST_SCAN;
            end
         end

         emsr_pkg::ST_SCAN: begin
            if (hit) begin
               idx_in = '0;
               if (phase_ff == emsr_pkg::PH_FIND) begin
                  k_in   = ridx_ff;
                  ent_in = rd;
                  if (cmd_ff == emsr_pkg::CMD_LOOKUP) begin
                     resp_now    = 1'b1;
                     resp_found  = 1'b1;
                     resp_mapped = rd.ps + (sec_ff - rd.ls);
                  end else if (rd.len == SW'(1)) begin
                     if (sec_ff == '0) begin
                        we       = 1'b1;
                        waddr    = ridx_ff;
                        wdata    = '{ls: rd.ls, ps: phys_ff, len: rd.len};
                        resp_now = 1'b1;
                     end else begin
                        phase_in  = emsr_pkg::PH_PREV;
                        single_in = 1'b1;
                     end
                  end else if (rd.ls == sec_ff) begin
                     // trim at the low end, then look again
                     we    = 1'b1;
                     waddr = ridx_ff;
                     wdata = '{ls: rd.ls + 1'b1, ps: rd.ps + 1'b1, len: rd.len - 1'b1};
                  end else if (({1'b0, rd.ls} + {1'b0, rd.len}) == ({1'b0, sec_ff} + 1'b1)) begin
                     we    = 1'b1;
                     waddr = ridx_ff;
                     wdata = '{ls: rd.ls, ps: rd.ps, len: rd.len - 1'b1};
                  end else begin
                     // split: keep lower part here, upper part appended next if the table is not full
                     we       = 1'b1;
                     waddr    = ridx_ff;
                     wdata    = '{ls: rd.ls, ps: rd.ps, len: sec_ff - rd.ls};
                     state_in = emsr_pkg::ST_APPEND;
                  end
               end else if (cont) begin
                  we    = 1'b1;
                  waddr = ridx_ff;
                  wdata = '{ls: rd.ls, ps: rd.ps, len: rd.len + 1'b1};
                  if (single_ff) begin
                     idx_in   = CNT_W'(k_ff) + 1'b1;
                     state_in = emsr_pkg::ST_SHIFT;
                  end else begin
                     resp_now = 1'b1;
                  end
               end else if (single_ff) begin
                  we       = 1'b1;
                  waddr    = k_ff;
                  wdata    = '{ls: ent_ff.ls, ps: phys_ff, len: ent_ff.len};
                  resp_now = 1'b1;
               end else begin
                  resp_now = 1'b1;
                  if (full) begin
                     wr_in       = 1'b0;
                     resp_status = 1'b1;
                  end else begin
                     we       = 1'b1;
                     waddr    = count_ff[IDX_W-1:0];
                     wdata    = '{ls: sec_ff, ps: phys_ff, len: SW'(1)};
                     count_in = count_ff + 1'b1;
                  end
               end
            end else if (idx_ff < count_ff) begin
               rv_in   = 1'b1;
               ridx_in = idx_ff[IDX_W-1:0];
               idx_in  = idx_ff + 1'b1;
            end else begin
               // miss
               idx_in = '0;
               if (cmd_ff == emsr_pkg::CMD_LOOKUP) begin
                  resp_now = 1'b1;
               end else if (phase_ff == emsr_pkg::PH_FIND && sec_ff != '0) begin
                  phase_in  = emsr_pkg::PH_PREV;
                  single_in = 1'b0;
               end else if (phase_ff == emsr_pkg::PH_PREV && single_ff) begin
                  we       = 1'b1;
                  waddr    = k_ff;
                  wdata    = '{ls: ent_ff.ls, ps: phys_ff, len: ent_ff.len};
                  resp_now = 1'b1;
               end else begin
                  resp_now = 1'b1;
                  if (full) begin
                     wr_in       = 1'b0;
                     resp_status = 1'b1;
                  end else begin
                     we       = 1'b1;
                     waddr    = count_ff[IDX_W-1:0];
                     wdata    = '{ls: sec_ff, ps: phys_ff, len: SW'(1)};
                     count_in = count_ff + 1'b1;
                  end
               end
            end
         end

         emsr_pkg::ST_APPEND: begin
            idx_in   = '0;
            phase_in = emsr_pkg::PH_FIND;
            state_in = emsr_pkg::ST_SCAN;
            if (full) begin
               wr_in = 1'b0;
            end else begin
               we       = 1'b1;
               waddr    = count_ff[IDX_W-1:0];
               wdata    = '{ls: sec_ff + 1'b1, ps: ent_ff.ps + lo + 1'b1,
                            len: ent_ff.len - lo - 1'b1};
               count_in = count_ff + 1'b1;
            end
         end

         emsr_pkg::ST_SHIFT: begin
            // read entry j+1, write it to j in the next cycle
            if (rv_ff) begin
               we    = 1'b1;
               waddr = ridx_ff - 1'b1;
               wdata = rd;
            end
            if (idx_ff < count_ff) begin
               rv_in   = 1'b1;
               ridx_in = idx_ff[IDX_W-1:0];
               idx_in  = idx_ff + 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
               resp_now = 1'b1;
            end
         end

         default: begin
            state_in = emsr_pkg::ST_IDLE;
         end
      endcase

      if (resp_now) begin
         state_in = emsr_pkg::ST_IDLE;
      end
      rsp_valid_in = resp_now;
      rsp_in       = '{found: resp_found, mapped_sector: resp_mapped, status: resp_status,
                       writable: wr_in, extent_count: emsr_pkg::COUNT_OUT_W'(count_in)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= emsr_pkg::ST_IDLE;
         count_ff     <= '0;
         wr_ff        <= 1'b1;
         rv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wr_ff        <= wr_in;
         rv_ff        <= rv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff  <= phase_in;
      cmd_ff    <= cmd_in;
      sec_ff    <= sec_in;
      phys_ff   <= phys_in;
      single_ff <= single_in;
      k_ff      <= k_in;
      ent_ff    <= ent_in;
      idx_ff    <= idx_in;
      ridx_ff   <= ridx_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != emsr_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the extent map remapper against an in-bench model of the extent
// table; lookup and map requests with bursty issue, split/trim/delete cases
// and overflow of the extent table.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 256;
   localparam int IDLE_LIMIT  = 200000;
   localparam logic [30:0] M31 = 31'h7FFFFFFF;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   emsr_pkg::req_type req_data;
   logic              rsp_valid;
   emsr_pkg::rsp_type rsp_data;

   extent_map_sector_remapper_top #(.MAX_EXTENTS(TABLE_DEPTH)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   // table model
   logic [31:0] tbl_ls  [TABLE_DEPTH];
   logic [31:0] tbl_ps  [TABLE_DEPTH];
   logic [31:0] tbl_len [TABLE_DEPTH];
   int          tbl_n;
   logic        tbl_wr;

   emsr_pkg::req_type pending_reqs[$];
   emsr_pkg::rsp_type expected_rsps[$];
   int      errors;
   int      idle_cycles;
   bit      hold_for_drain;
   int      burst_left;
   int      gap_left;

   function automatic int find_extent(logic [31:0] sec);
      for (int i = 0; i < tbl_n; i++) begin
         if (tbl_ls[i] <= sec && {32'd0, tbl_ls[i]} + tbl_len[i] > {32'd0, sec})
            return i;
      end
      return -1;
   endfunction

   function automatic int find_prev(logic [31:0] sec, logic [31:0] phys);
      int p;
      if (sec == 0) return -1;
      p = find_extent(sec - 1);
      if (p < 0) return -1;
      if ({32'd0, tbl_ls[p]} + tbl_len[p] == {32'd0, sec} &&
          {32'd0, tbl_ps[p]} + tbl_len[p] == {32'd0, phys})
         return p;
      return -1;
   endfunction

   function automatic logic add_extent(logic [31:0] ls, logic [31:0] ps, logic [31:0] len);
      if (tbl_n >= TABLE_DEPTH) begin
         tbl_wr = 1'b0;
         return 1'b1;
      end
      tbl_ls[tbl_n]  = ls & M31;
      tbl_ps[tbl_n]  = ps & M31;
      tbl_len[tbl_n] = len & M31;
      tbl_n++;
      return 1'b0;
   endfunction

   function automatic logic remap_sector(logic [31:0] sec, logic [31:0] phys);
      int          f;
      int          p;
      logic [31:0] lo;
      logic [31:0] hi;
      logic        dummy;
      for (int g = 0; g <= TABLE_DEPTH + 1; g++) begin
         f = find_extent(sec);
         if (f < 0) begin
            p = find_prev(sec, phys);
            if (p >= 0) begin
               tbl_len[p] = (tbl_len[p] + 1) & M31;
               return 1'b0;
            end
            return add_extent(sec, phys, 1);
         end
         if (tbl_len[f] == 1) begin
            p = find_prev(sec, phys);
            if (p >= 0) begin
               tbl_len[p] = (tbl_len[p] + 1) & M31;
               for (int j = f; j + 1 < tbl_n; j++) begin
                  tbl_ls[j]  = tbl_ls[j+1];
                  tbl_ps[j]  = tbl_ps[j+1];
                  tbl_len[j] = tbl_len[j+1];
               end
               tbl_n--;
               return 1'b0;
            end
            tbl_ps[f] = phys & M31;
            return 1'b0;
         end
         if (tbl_ls[f] == sec) begin
            tbl_ls[f]  = (tbl_ls[f] + 1) & M31;
            tbl_ps[f]  = (tbl_ps[f] + 1) & M31;
            tbl_len[f] = (tbl_len[f] - 1) & M31;
         end else if ({32'd0, tbl_ls[f]} + tbl_len[f] == {32'd0, sec} + 1) begin
            tbl_len[f] = (tbl_len[f] - 1) & M31;
         end else begin
            lo = sec - tbl_ls[f];
            hi = tbl_len[f] - lo - 1;
            tbl_len[f] = lo & M31;
            dummy = add_extent(sec + 1, tbl_ps[f] + lo + 1, hi);
         end
      end
      return 1'b0;
   endfunction

   function automatic emsr_pkg::rsp_type predict_rsp(emsr_pkg::req_type r);
      emsr_pkg::rsp_type o;
      int                f;
      logic [31:0]       sec;
      sec = {1'b0, r.logical_sector};
      o = '0;
      if (r.cmd == emsr_pkg::CMD_LOOKUP) begin
         f = find_extent(sec);
         if (f >= 0) begin
            o.found = 1'b1;
            o.mapped_sector = 31'(tbl_ps[f] + (sec - tbl_ls[f]));
         end
      end else begin
         o.status = remap_sector(sec, {1'b0, r.physical_sector});
      end
      o.writable     = tbl_wr;
      o.extent_count = 9'(tbl_n);
      return o;
   endfunction

   function automatic emsr_pkg::req_type make_req(emsr_pkg::cmd_type c, logic [30:0] ls,
                                                  logic [30:0] ps);
      emsr_pkg::req_type r;
      r.cmd = c;
      r.logical_sector = ls;
      r.physical_sector = ps;
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (gap_left > 0) gap_left--;
         if (hold_for_drain && expected_rsps.size() == 0 && !busy)
            hold_for_drain = 1'b0;
         if (pending_reqs.size() > 0 && gap_left == 0 && !hold_for_drain && !busy) begin
            start    <= 1'b1;
            req_data <= pending_reqs[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      emsr_pkg::rsp_type e;
      if (!reset) begin
         idle_cycles++;
         if (start && !busy) begin
            expected_rsps.push_back(predict_rsp(req_data));
            void'(pending_reqs.pop_front());
            idle_cycles = 0;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end
            // one drain pause in the middle of the run
            if (pending_reqs.size() == 300) hold_for_drain = 1'b1;
         end
         if (rsp_valid) begin
            idle_cycles = 0;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response %p", $realtime, rsp_data);
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_data.found !== e.found || rsp_data.mapped_sector !== e.mapped_sector
                   || rsp_data.status !== e.status || rsp_data.writable !== e.writable
                   || rsp_data.extent_count !== e.extent_count) begin
                  $display("%0t: mismatch expected %p actual %p", $realtime, e, rsp_data);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      logic [30:0] base;
      logic [30:0] pbase;
      int          tail;
      errors = 0; idle_cycles = 0; hold_for_drain = 1'b0;
      burst_left = 0; gap_left = 0;
      tbl_n = 0; tbl_wr = 1'b1;
      reset = 1'b1; start = 1'b0; req_data = '0;

      // directed: empty lookup, extremes, extend, trims, split, delete
      pending_reqs.push_back(make_req(emsr_pkg::CMD_LOOKUP, 31'd0, M31));
      pending_reqs.push_back(make_req(emsr_pkg::CMD_MAP, 31'd0, 31'd100));
      pending_reqs.push_back(make_req(emsr_pkg::CMD_MAP, 31'd1, 31'd101));
      pending_reqs.push_back(make_req(emsr_pkg::CMD_MAP, 31'd2, 31'd102));
      pending_reqs.push_back(make_req(emsr_pkg::CMD_MAP, 31'd3, 31'd103));
      pending_reqs.push_back(make_req(emsr_pkg::CMD_MAP, 31'd4, 31'd104));
      pending_reqs.push_back(make_req(emsr_pkg::CMD_LOOKUP, 31'd3, 31'd0));
      pending_reqs.push_back(make_req(emsr_pkg::CMD_MAP, 31'd2, 31'd500));
      pending_reqs.push_back(make_req(emsr_pkg::CMD_MAP, 31'd0, 31'd600));
      pending_reqs.push_back(make_req(emsr_pkg::CMD_MAP, 31'd4, 31'd700));
      pending_reqs.push_back(make_req(emsr_pkg::CMD_MAP, 31'd2, 31'd103));
      pending_reqs.push_back(make_req(emsr_pkg::CMD_MAP, 31'd2, 31'd102));
      pending_reqs.push_back(make_req(emsr_pkg::CMD_MAP, M31, M31));
      pending_reqs.push_back(make_req(emsr_pkg::CMD_MAP, M31 - 31'd1, M31 - 31'd1));
      pending_reqs.push_back(make_req(emsr_pkg::CMD_LOOKUP, M31, 31'd0));
      pending_reqs.push_back(make_req(emsr_pkg::CMD_LOOKUP, M31 - 31'd1, M31));
      pending_reqs.push_back(make_req(emsr_pkg::CMD_MAP, M31, 31'd0));
      pending_reqs.push_back(make_req(emsr_pkg::CMD_LOOKUP, 31'd1, 31'd0));
      pending_reqs.push_back(make_req(emsr_pkg::CMD_LOOKUP, 31'd9, 31'd0));

      // random: runs of sequential maps with random remaps inside a small window
      for (int i = 0; i < 330; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            pending_reqs.push_back(make_req(emsr_pkg::cmd_type'($urandom_range(0, 1)),
                                            31'($urandom), 31'($urandom)));
         end else begin
            base  = 31'($urandom_range(0, 63));
            pbase = ($urandom_range(0, 1)) ? 31'($urandom_range(0, 4000)) : 31'($urandom);
            tail  = $urandom_range(0, 2);
            for (int k = 0; k <= tail; k++)
               pending_reqs.push_back(make_req(emsr_pkg::CMD_MAP, base + 31'(k),
                                               pbase + 31'(k)));
            pending_reqs.push_back(make_req(emsr_pkg::CMD_LOOKUP,
                                            31'($urandom_range(0, 70)), 31'($urandom)));
         end
         if (pending_reqs.size() > 288) break;
      end
      // fill the table past capacity with scattered sectors, then split on full
      for (int i = 0; i < 270; i++)
         pending_reqs.push_back(make_req(emsr_pkg::CMD_MAP, 31'(1000 + 2 * i),
                                         31'($urandom)));
      pending_reqs.push_back(make_req(emsr_pkg::CMD_MAP, 31'd1, 31'd9));
      pending_reqs.push_back(make_req(emsr_pkg::CMD_LOOKUP, 31'd1002, 31'd0));
      for (int i = 0; i < 20; i++)
         pending_reqs.push_back(make_req(emsr_pkg::cmd_type'($urandom_range(0, 1)),
                                         31'($urandom_range(990, 1600)), 31'($urandom)));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while ((pending_reqs.size() > 0 || expected_rsps.size() > 0) &&
             idle_cycles < IDLE_LIMIT)
         @(posedge clock);
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         repeat (2000) @(posedge clock);
         if (errors == 0 && expected_rsps.size() == 0)
            $display("All tests passed");
         else
            $display("Some tests failed");
         $finish;
      end
   end

endmodule

`default_nettype wire
